### hdl/cp15te_pkg.sv
// Shared types, codes and register tables for the coprocessor trap emulator.
`timescale 1ns / 1ps

package cp15te_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_ACTLR  = 2'd0;
   localparam logic [1:0] CSR_L2CTLR = 2'd1;
   localparam logic [1:0] CSR_TGTSEL = 2'd2;

   // Status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_UNSUP = 3'd1;
   localparam logic [2:0] ST_WR_RO = 3'd2;
   localparam logic [2:0] ST_RD_WO = 3'd3;
   localparam logic [2:0] ST_NOACC = 3'd4;

   // Cache maintenance commands
   localparam logic [1:0] COP_NONE     = 2'd0;
   localparam logic [1:0] COP_CLEAN_INV = 2'd1;
   localparam logic [1:0] COP_CLEAN    = 2'd2;
   localparam logic [1:0] COP_FLUSH_ALL = 2'd3;

   // CRm encodings of the set/way operations
   localparam logic [3:0] CRM_DCISW  = 4'd6;
   localparam logic [3:0] CRM_DCCSW  = 4'd10;
   localparam logic [3:0] CRM_DCCISW = 4'd14;

   localparam int TGT_ENTRIES = 7;
   localparam int GEN_ENTRIES = 34;

   typedef enum logic [2:0] {
      POL_NONE   = 3'd0,
      POL_RAZWI  = 3'd1,
      POL_ACTLR  = 3'd2,
      POL_L2CTLR = 3'd3,
      POL_CBAR   = 3'd4,
      POL_DCSW   = 3'd5
   } pol_type;

   typedef struct packed {
      logic [3:0] crn;
      logic [3:0] crm;
      logic [3:0] op1;
      logic [2:0] op2;
      logic       wide;
      pol_type    pol;
   } entry_type;

   // Decoded access coordinates
   typedef struct packed {
      logic [3:0] crn;
      logic [3:0] crm;
      logic [3:0] op1;
      logic [2:0] op2;
      logic       wide;
   } coord_type;

   // Table lookup outcome
   typedef struct packed {
      logic    found;
      pol_type pol;
   } match_type;

   typedef struct packed {
      logic        kind;
      logic [25:0] syndrome;
      logic [31:0] rt_value;
      logic        same_cpu;
   } req_type;

   typedef struct packed {
      logic        inject_undefined;
      logic [2:0]  status;
      logic        reg_write_valid;
      logic [3:0]  reg_write_index;
      logic [31:0] reg_write_data;
      logic        long_instruction;
      logic [1:0]  cache_op;
      logic [31:0] cache_op_operand;
      logic        mark_other_cpus;
   } rsp_type;

   // Target-specific registers (crn, crm, op1, op2, wide, policy)
   localparam entry_type TGT_TAB [TGT_ENTRIES] = '{
      '{4'd0,  4'd0, 4'd0, 3'd5, 1'b0, POL_NONE},
      '{4'd1,  4'd0, 4'd0, 3'd0, 1'b0, POL_NONE},
      '{4'd1,  4'd0, 4'd0, 3'd1, 1'b0, POL_ACTLR},
      '{4'd1,  4'd0, 4'd0, 3'd2, 1'b0, POL_NONE},
      '{4'd9,  4'd0, 4'd1, 3'd2, 1'b0, POL_L2CTLR},
      '{4'd9,  4'd0, 4'd1, 3'd3, 1'b0, POL_RAZWI},
      '{4'd15, 4'd0, 4'd4, 3'd0, 1'b0, POL_CBAR}
   };

   // Generic registers
   localparam entry_type GEN_TAB [GEN_ENTRIES] = '{
      '{4'd0,  4'd0,  4'd2, 3'd0, 1'b0, POL_NONE},
      '{4'd0,  4'd2,  4'd0, 3'd0, 1'b1, POL_NONE},
      '{4'd0,  4'd2,  4'd1, 3'd0, 1'b1, POL_NONE},
      '{4'd2,  4'd0,  4'd0, 3'd2, 1'b0, POL_NONE},
      '{4'd3,  4'd0,  4'd0, 3'd0, 1'b0, POL_NONE},
      '{4'd5,  4'd0,  4'd0, 3'd0, 1'b0, POL_NONE},
      '{4'd5,  4'd0,  4'd0, 3'd1, 1'b0, POL_NONE},
      '{4'd5,  4'd1,  4'd0, 3'd0, 1'b0, POL_NONE},
      '{4'd5,  4'd1,  4'd0, 3'd1, 1'b0, POL_NONE},
      '{4'd6,  4'd0,  4'd0, 3'd0, 1'b0, POL_NONE},
      '{4'd6,  4'd0,  4'd0, 3'd2, 1'b0, POL_NONE},
      '{4'd7,  4'd6,  4'd0, 3'd2, 1'b0, POL_DCSW},
      '{4'd7,  4'd10, 4'd0, 3'd2, 1'b0, POL_DCSW},
      '{4'd7,  4'd14, 4'd0, 3'd2, 1'b0, POL_DCSW},
      '{4'd9,  4'd12, 4'd0, 3'd0, 1'b0, POL_RAZWI},
      '{4'd9,  4'd12, 4'd0, 3'd1, 1'b0, POL_RAZWI},
      '{4'd9,  4'd12, 4'd0, 3'd2, 1'b0, POL_RAZWI},
      '{4'd9,  4'd12, 4'd0, 3'd3, 1'b0, POL_RAZWI},
      '{4'd9,  4'd12, 4'd0, 3'd5, 1'b0, POL_RAZWI},
      '{4'd9,  4'd12, 4'd0, 3'd6, 1'b0, POL_RAZWI},
      '{4'd9,  4'd12, 4'd0, 3'd7, 1'b0, POL_RAZWI},
      '{4'd9,  4'd13, 4'd0, 3'd0, 1'b0, POL_RAZWI},
      '{4'd9,  4'd13, 4'd0, 3'd1, 1'b0, POL_RAZWI},
      '{4'd9,  4'd13, 4'd0, 3'd2, 1'b0, POL_RAZWI},
      '{4'd9,  4'd14, 4'd0, 3'd0, 1'b0, POL_RAZWI},
      '{4'd9,  4'd14, 4'd0, 3'd1, 1'b0, POL_RAZWI},
      '{4'd9,  4'd14, 4'd0, 3'd2, 1'b0, POL_RAZWI},
      '{4'd10, 4'd2,  4'd0, 3'd0, 1'b0, POL_NONE},
      '{4'd10, 4'd2,  4'd0, 3'd1, 1'b0, POL_NONE},
      '{4'd12, 4'd0,  4'd0, 3'd0, 1'b0, POL_NONE},
      '{4'd13, 4'd0,  4'd0, 3'd1, 1'b0, POL_NONE},
      '{4'd13, 4'd0,  4'd0, 3'd2, 1'b0, POL_NONE},
      '{4'd13, 4'd0,  4'd0, 3'd3, 1'b0, POL_NONE},
      '{4'd13, 4'd0,  4'd0, 3'd4, 1'b0, POL_NONE}
   };

endpackage

### hdl/cp15te_lookup.sv
// Syndrome field decode and register table match.
`timescale 1ns / 1ps

module cp15te_lookup
   import cp15te_pkg::*;
(
   input  req_type   req,
   input  logic      target_is_a15,
   output match_type match
);

   coord_type coord;
   match_type tgt_match;
   match_type gen_match;

   // Field decode; wide accesses carry a 4-bit Op1 and no CRn/Op2
   always_comb begin
      coord.wide = req.kind;
      coord.crm  = req.syndrome[4:1];
      if (req.kind) begin
         coord.crn = 4'd0;
         coord.op1 = req.syndrome[19:16];
         coord.op2 = 3'd0;
      end else begin
         coord.crn = req.syndrome[13:10];
         coord.op1 = {1'b0, req.syndrome[16:14]};
         coord.op2 = req.syndrome[19:17];
      end
   end

   // Parallel compares; scan from the end so the first hit wins
   always_comb begin
      tgt_match = '{found: 1'b0, pol: POL_NONE};
      for (int i = TGT_ENTRIES - 1; i >= 0; i--) begin
         if (TGT_TAB[i].wide == coord.wide && TGT_TAB[i].crn == coord.crn &&
             TGT_TAB[i].crm == coord.crm && TGT_TAB[i].op1 == coord.op1 &&
             TGT_TAB[i].op2 == coord.op2) begin
            tgt_match = '{found: 1'b1, pol: TGT_TAB[i].pol};
         end
      end
   end

   always_comb begin
      gen_match = '{found: 1'b0, pol: POL_NONE};
      for (int i = GEN_ENTRIES - 1; i >= 0; i--) begin
         if (GEN_TAB[i].wide == coord.wide && GEN_TAB[i].crn == coord.crn &&
             GEN_TAB[i].crm == coord.crm && GEN_TAB[i].op1 == coord.op1 &&
             GEN_TAB[i].op2 == coord.op2) begin
            gen_match = '{found: 1'b1, pol: GEN_TAB[i].pol};
         end
      end
   end

   // Target table has priority when enabled
   assign match = (target_is_a15 && tgt_match.found) ? tgt_match : gen_match;

endmodule

### hdl/cp15te_policy.sv
// Applies the matched register policy and forms the result beat.
`timescale 1ns / 1ps

module cp15te_policy
   import cp15te_pkg::*;
(
   input  req_type     req,
   input  match_type   match,
   input  logic [31:0] actlr_value,
   input  logic [31:0] l2ctlr_value,
   output rsp_type     rsp
);

   logic        wr_access;
   logic        undef;
   logic [2:0]  status;
   logic        wv;
   logic [31:0] wdata;
   logic [1:0]  cop;
   logic [31:0] copnd;
   logic        mark;

   assign wr_access = ~req.syndrome[0];

   always_comb begin
      undef  = 1'b1;
      status = ST_UNSUP;
      wv     = 1'b0;
      wdata  = 32'd0;
      cop    = COP_NONE;
      copnd  = 32'd0;
      mark   = 1'b0;
      if (match.found) begin
         undef  = 1'b0;
         status = ST_OK;
         case (match.pol)
            POL_RAZWI: begin
               wv = ~wr_access;
            end
            POL_ACTLR: begin
               wv    = ~wr_access;
               wdata = actlr_value;
            end
            POL_L2CTLR: begin
               wv    = ~wr_access;
               wdata = l2ctlr_value;
            end
            POL_CBAR: begin
               if (wr_access) begin
                  undef  = 1'b1;
                  status = ST_WR_RO;
               end else begin
                  wv = 1'b1;
               end
            end
            POL_DCSW: begin
               if (!wr_access) begin
                  undef  = 1'b1;
                  status = ST_RD_WO;
               end else begin
                  mark = 1'b1;
                  // off-cpu set/way cannot be replayed: flush everything
                  if (!req.same_cpu) begin
                     cop = COP_FLUSH_ALL;
                  end else if (req.syndrome[4:1] == CRM_DCISW ||
                               req.syndrome[4:1] == CRM_DCCISW) begin
                     cop   = COP_CLEAN_INV;
                     copnd = req.rt_value;
                  end else if (req.syndrome[4:1] == CRM_DCCSW) begin
                     cop   = COP_CLEAN;
                     copnd = req.rt_value;
                  end
               end
            end
            default: begin
               undef  = 1'b1;
               status = ST_NOACC;
            end
         endcase
      end
   end

   // Result assembly; write-back fields zero unless a write-back happens
   always_comb begin
      rsp.inject_undefined = undef;
      rsp.status           = status;
      rsp.reg_write_valid  = wv;
      rsp.reg_write_index  = wv ? req.syndrome[8:5] : 4'd0;
      rsp.reg_write_data   = wv ? wdata : 32'd0;
      rsp.long_instruction = req.syndrome[25];
      rsp.cache_op         = cop;
      rsp.cache_op_operand = copnd;
      rsp.mark_other_cpus  = mark;
   end

endmodule

### hdl/cp15_trap_emulator.sv
// Top level of the trapped coprocessor access emulator.
`timescale 1ns / 1ps
//
//  Channel  Prefix  Direction  Payload
//  -------  ------  ---------  ----------------------------------------
//  trap     req_    in         req_type: kind, syndrome, rt_value, same_cpu
//  result   rsp_    out        rsp_type: one beat per trap
//  config   csr_    in         write enable, 2-bit index, 32-bit data
//
//  Two register stages: input register, then table lookup and policy logic
//  into the result register. One trap per cycle while req_stall is low.
//  Synchronous reset clears the valid flags and config registers
//  (target table enabled). A held rsp_stall stalls the output register and,
//  once the input register is also full, raises req_stall the same cycle.

module cp15_trap_emulator
   import cp15te_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,

   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [31:0] actlr_value_ff;
   logic [31:0] l2ctlr_value_ff;
   logic        tgt_sel_ff;

   logic        in_valid_ff;
   logic        in_valid_in;
   req_type     in_data_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   rsp_type     out_data_ff;

   logic        out_free;
   logic        req_take;
   match_type   match;
   rsp_type     rsp_next;

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         actlr_value_ff  <= 32'd0;
         l2ctlr_value_ff <= 32'd0;
         tgt_sel_ff      <= 1'b1;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_ACTLR:  actlr_value_ff  <= csr_wdata;
            CSR_L2CTLR: l2ctlr_value_ff <= csr_wdata;
            CSR_TGTSEL: tgt_sel_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Pipeline flow control
   assign out_free     = ~out_valid_ff | ~rsp_stall;
   assign req_stall    = in_valid_ff & ~out_free;
   assign req_take     = req_valid & ~req_stall;
   assign in_valid_in  = req_take | (in_valid_ff & ~out_free);
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   cp15te_lookup u_lookup (
      .req           (in_data_ff),
      .target_is_a15 (tgt_sel_ff),
      .match         (match)
   );

   cp15te_policy u_policy (
      .req          (in_data_ff),
      .match        (match),
      .actlr_value  (actlr_value_ff),
      .l2ctlr_value (l2ctlr_value_ff),
      .rsp          (rsp_next)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && in_valid_ff) begin
         out_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
